@@ hw/rtl/svrc_pkg.sv @@
// Package for the sous-vide relay controller: field widths, reset values,
// register indexes, the one-hot mode encoding and shared structs.
// Depends on nothing; every other file of the block refers to it.
package svrc_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int SUM_W      = 14;
  localparam int ADJ_W      = 10;
  localparam int INTERVAL_W = 8;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [SUM_W-1:0]      HEAT_EXIT_RESET = 14'd1464;
  localparam logic [SUM_W-1:0]      REGULATE_RESET  = 14'd1436;
  localparam logic [ADJ_W-1:0]      ADJUST_RESET    = 10'd45;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = 8'd60;
  localparam logic [SUM_W-1:0]      SUM_MAX         = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAT_EXIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGULATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd3;

  localparam logic [MODE_W-1:0] CODE_HEAT     = 2'd0;
  localparam logic [MODE_W-1:0] CODE_COAST    = 2'd1;
  localparam logic [MODE_W-1:0] CODE_REGULATE = 2'd2;

  typedef enum logic [2:0] {
    MODE_HEAT     = 3'b001,
    MODE_COAST    = 3'b010,
    MODE_REGULATE = 3'b100
  } mode_t;

  typedef struct packed {
    logic [SUM_W-1:0]      heat_exit_sum;
    logic [SUM_W-1:0]      regulate_sum;
    logic [ADJ_W-1:0]      relay_adjust_sum;
    logic [INTERVAL_W-1:0] peak_check_interval;
  } cfg_t;

  typedef struct packed {
    logic             relay_on;
    logic [MODE_W-1:0] control_mode;
    logic [SUM_W-1:0] adjusted_sum;
  } status_t;

endpackage

@@ hw/rtl/svrc_cfg.sv @@
// Configuration register file of the sous-vide relay controller.
// Depends on svrc_pkg for the register indexes, widths and reset values.
module svrc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [svrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [svrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output svrc_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heat_exit_sum       <= svrc_pkg::HEAT_EXIT_RESET;
      cfg.regulate_sum        <= svrc_pkg::REGULATE_RESET;
      cfg.relay_adjust_sum    <= svrc_pkg::ADJUST_RESET;
      cfg.peak_check_interval <= svrc_pkg::INTERVAL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        svrc_pkg::CFG_HEAT_EXIT: begin
          cfg.heat_exit_sum <= cfg_data[svrc_pkg::SUM_W-1:0];
        end
        svrc_pkg::CFG_REGULATE: begin
          cfg.regulate_sum <= cfg_data[svrc_pkg::SUM_W-1:0];
        end
        svrc_pkg::CFG_ADJUST: begin
          cfg.relay_adjust_sum <= cfg_data[svrc_pkg::ADJ_W-1:0];
        end
        svrc_pkg::CFG_INTERVAL: begin
          cfg.peak_check_interval <= cfg_data[svrc_pkg::INTERVAL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/svrc_accum.sv @@
// Sample accumulator: sums groups of samples into one reading and applies
// the relay-on correction. Depends on svrc_pkg for widths.
module svrc_accum #(
  parameter int NUM_SAMPLES = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [svrc_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           relay,
  input  logic [svrc_pkg::ADJ_W-1:0]     adjust,
  output logic                           done,
  output logic [svrc_pkg::SUM_W-1:0]     reading
);

  localparam int CNT_W = $clog2(NUM_SAMPLES + 1);

  logic [CNT_W-1:0]            sample_index;
  logic [svrc_pkg::SUM_W-1:0]  running_sum;
  logic [CNT_W-1:0]            index_inc;
  logic [svrc_pkg::SUM_W:0]    sum_wide;
  logic [svrc_pkg::SUM_W-1:0]  sum_sat;
  logic [svrc_pkg::SUM_W-1:0]  adjust_wide;

  assign index_inc   = sample_index + CNT_W'(1);
  assign done        = index_inc >= CNT_W'(NUM_SAMPLES);
  assign sum_wide    = {1'b0, running_sum} + (svrc_pkg::SUM_W + 1)'(sample);
  assign sum_sat     = sum_wide[svrc_pkg::SUM_W] ? svrc_pkg::SUM_MAX
                                                 : sum_wide[svrc_pkg::SUM_W-1:0];
  assign adjust_wide = svrc_pkg::SUM_W'(adjust);

  always_comb begin
    if (!relay) begin
      reading = sum_sat;
    end else if (sum_sat > adjust_wide) begin
      reading = sum_sat - adjust_wide;
    end else begin
      reading = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      running_sum  <= '0;
    end else if (step) begin
      if (done) begin
        sample_index <= '0;
        running_sum  <= '0;
      end else begin
        sample_index <= index_inc;
        running_sum  <= sum_sat;
      end
    end
  end

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    sample_index < CNT_W'(NUM_SAMPLES))
    else $error("sample index has reached the group size");

endmodule

@@ hw/rtl/svrc_ctrl.sv @@
// Three-mode relay controller acting on each completed reading.
// Depends on svrc_pkg for the mode encoding, cfg_t and status_t.
module svrc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          done,
  input  logic [svrc_pkg::SUM_W-1:0]    reading,
  input  svrc_pkg::cfg_t                cfg,
  output logic                          relay,
  output svrc_pkg::status_t             status_next
);

  svrc_pkg::mode_t                     mode, mode_next;
  logic                                relay_next;
  logic [svrc_pkg::SUM_W-1:0]          prior_sum, prior_sum_next;
  logic [svrc_pkg::INTERVAL_W-1:0]     interval_count, interval_count_next;
  logic [svrc_pkg::SUM_W-1:0]          last_reading, last_reading_next;
  logic [svrc_pkg::INTERVAL_W:0]       interval_inc;

  assign interval_inc = {1'b0, interval_count} + (svrc_pkg::INTERVAL_W + 1)'(1);

  always_comb begin
    mode_next           = mode;
    relay_next          = relay;
    prior_sum_next      = prior_sum;
    interval_count_next = interval_count;
    last_reading_next   = last_reading;
    if (step && done) begin
      last_reading_next = reading;
      case (mode)
        svrc_pkg::MODE_HEAT: begin
          if (reading < cfg.heat_exit_sum) begin
            relay_next          = 1'b0;
            mode_next           = svrc_pkg::MODE_COAST;
            interval_count_next = '0;
          end
        end
        svrc_pkg::MODE_COAST: begin
          relay_next = 1'b0;
          if (interval_count == '0) begin
            if (reading > prior_sum) begin
              mode_next = svrc_pkg::MODE_REGULATE;
            end
            prior_sum_next = reading;
          end
          if (interval_inc >= {1'b0, cfg.peak_check_interval}) begin
            interval_count_next = '0;
          end else begin
            interval_count_next = interval_inc[svrc_pkg::INTERVAL_W-1:0];
          end
        end
        default: begin
          relay_next = reading > cfg.regulate_sum;
        end
      endcase
    end
  end

  always_comb begin
    status_next.relay_on     = relay_next;
    status_next.adjusted_sum = last_reading_next;
    case (mode_next)
      svrc_pkg::MODE_HEAT:  status_next.control_mode = svrc_pkg::CODE_HEAT;
      svrc_pkg::MODE_COAST: status_next.control_mode = svrc_pkg::CODE_COAST;
      default:              status_next.control_mode = svrc_pkg::CODE_REGULATE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= svrc_pkg::MODE_HEAT;
      relay          <= 1'b1;
      prior_sum      <= svrc_pkg::SUM_MAX;
      interval_count <= '0;
      last_reading   <= '0;
    end else begin
      mode           <= mode_next;
      relay          <= relay_next;
      prior_sum      <= prior_sum_next;
      interval_count <= interval_count_next;
      last_reading   <= last_reading_next;
    end
  end

  a_coast_relay_off: assert property (@(posedge clk) disable iff (rst)
    mode == svrc_pkg::MODE_COAST |-> !relay)
    else $error("relay is on while coasting");

  a_regulate_kept: assert property (@(posedge clk) disable iff (rst)
    mode == svrc_pkg::MODE_REGULATE |=> mode == svrc_pkg::MODE_REGULATE)
    else $error("controller left regulation");

  a_mode_only_on_reading: assert property (@(posedge clk) disable iff (rst)
    !(step && done) |=> $stable(mode) && $stable(last_reading))
    else $error("controller state changed without a completed reading");

endmodule

@@ hw/rtl/sous_vide_relay_controller.sv @@
// Sous-vide relay controller: one result transaction per sample transaction.
// An accepted sample waits in the input register until the result register
// can take it. Throughput: one sample per cycle while results are not stalled,
// limited by the single accumulate, correct and compare pass between them.
// Reset is synchronous and active high; it restores the register defaults,
// the relay on, initial heating and empty accumulator and pipeline.
module sous_vide_relay_controller #(
  parameter int NUM_SAMPLES = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [svrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [svrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [svrc_pkg::SAMPLE_W-1:0]    adc_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             relay_on,
  output logic [svrc_pkg::MODE_W-1:0]      control_mode,
  output logic                             reading_valid,
  output logic [svrc_pkg::SUM_W-1:0]       adjusted_sum
);

  svrc_pkg::cfg_t                 cfg;
  svrc_pkg::status_t              status_next;
  logic                           s1_valid;
  logic [svrc_pkg::SAMPLE_W-1:0]  s1_sample;
  logic                           advance;
  logic                           step;
  logic                           relay;
  logic                           done;
  logic [svrc_pkg::SUM_W-1:0]     reading;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign step      = s1_valid && advance;
  assign in_stall  = s1_valid && !advance;

  svrc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  svrc_accum #(
    .NUM_SAMPLES (NUM_SAMPLES)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .sample  (s1_sample),
    .relay   (relay),
    .adjust  (cfg.relay_adjust_sum),
    .done    (done),
    .reading (reading)
  );

  svrc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .done        (done),
    .reading     (reading),
    .cfg         (cfg),
    .relay       (relay),
    .status_next (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= adc_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      relay_on      <= status_next.relay_on;
      control_mode  <= status_next.control_mode;
      reading_valid <= done;
      adjusted_sum  <= status_next.adjusted_sum;
    end
  end

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_sample))
    else $error("input register changed while the result was stalled");

  a_step_delivers: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed sample produced no result");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for sous_vide_relay_controller: drives ADC samples and
// register writes, predicts every status transaction and compares it.
// Depends on svrc_pkg and the controller RTL.
module testbench;

  localparam int N_SAMPLES   = 10;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                        relay;
    logic [svrc_pkg::MODE_W-1:0] mode;
    logic                        fresh;
    logic [svrc_pkg::SUM_W-1:0]  sum;
  } status_exp_t;

  logic                            clk        = 1'b0;
  logic                            rst        = 1'b1;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [svrc_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [svrc_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
  logic                            in_valid   = 1'b0;
  logic                            in_stall;
  logic [svrc_pkg::SAMPLE_W-1:0]   adc_sample = '0;
  logic                            out_valid;
  logic                            out_stall  = 1'b0;
  logic                            relay_on;
  logic [svrc_pkg::MODE_W-1:0]     control_mode;
  logic                            reading_valid;
  logic [svrc_pkg::SUM_W-1:0]      adjusted_sum;

  // Controller state as the bench expects it to evolve.
  logic [svrc_pkg::SUM_W-1:0]      heat_exit_thr  = svrc_pkg::HEAT_EXIT_RESET;
  logic [svrc_pkg::SUM_W-1:0]      regulate_thr   = svrc_pkg::REGULATE_RESET;
  logic [svrc_pkg::ADJ_W-1:0]      relay_adjust   = svrc_pkg::ADJUST_RESET;
  logic [svrc_pkg::INTERVAL_W-1:0] check_interval = svrc_pkg::INTERVAL_RESET;
  logic [6:0]                      sample_count   = '0;
  logic [svrc_pkg::SUM_W-1:0]      partial_sum    = '0;
  logic [svrc_pkg::MODE_W-1:0]     coast_mode     = svrc_pkg::CODE_HEAT;
  logic                            relay_state    = 1'b1;
  logic [svrc_pkg::SUM_W-1:0]      peak_sum       = svrc_pkg::SUM_MAX;
  logic [svrc_pkg::INTERVAL_W-1:0] interval_cnt   = '0;
  logic [svrc_pkg::SUM_W-1:0]      last_sum       = '0;

  status_exp_t expected_status[$];
  status_exp_t head_status;
  int          error_count   = 0;
  int          cycle_count   = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  logic        hold_on       = 1'b0;

  sous_vide_relay_controller #(.NUM_SAMPLES(N_SAMPLES)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .adc_sample(adc_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .relay_on(relay_on), .control_mode(control_mode),
    .reading_valid(reading_valid), .adjusted_sum(adjusted_sum)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && (hold_on || ($urandom_range(99) < stall_pct));
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        head_status = expected_status.pop_front();
        if (relay_on !== head_status.relay)
          report_mismatch("relay_on", relay_on, head_status.relay);
        if (control_mode !== head_status.mode)
          report_mismatch("control_mode", control_mode, head_status.mode);
        if (reading_valid !== head_status.fresh)
          report_mismatch("reading_valid", reading_valid, head_status.fresh);
        if (adjusted_sum !== head_status.sum)
          report_mismatch("adjusted_sum", adjusted_sum, head_status.sum);
      end
    end
  end

  // Accumulates one sample and, on a completed reading, runs the controller.
  task automatic advance_controller(input logic [svrc_pkg::SAMPLE_W-1:0] sample);
    logic [svrc_pkg::SUM_W:0]   total;
    logic [svrc_pkg::SUM_W-1:0] reading;
    logic [svrc_pkg::SUM_W-1:0] adjust_ext;
    logic                       fresh;
    adjust_ext = svrc_pkg::SUM_W'(relay_adjust);
    total = {1'b0, partial_sum} + (svrc_pkg::SUM_W + 1)'(sample);
    if (total > {1'b0, svrc_pkg::SUM_MAX})
      total = {1'b0, svrc_pkg::SUM_MAX};
    partial_sum  = total[svrc_pkg::SUM_W-1:0];
    sample_count = sample_count + 7'd1;
    fresh        = 1'b0;
    if (sample_count >= 7'(N_SAMPLES)) begin
      reading = partial_sum;
      if (relay_state)
        reading = (reading > adjust_ext) ? reading - adjust_ext : '0;
      last_sum     = reading;
      partial_sum  = '0;
      sample_count = '0;
      fresh        = 1'b1;
      case (coast_mode)
        svrc_pkg::CODE_HEAT: begin
          if (reading < heat_exit_thr) begin
            relay_state  = 1'b0;
            coast_mode   = svrc_pkg::CODE_COAST;
            interval_cnt = '0;
          end
        end
        svrc_pkg::CODE_COAST: begin
          relay_state = 1'b0;
          if (interval_cnt == '0) begin
            if (reading > peak_sum)
              coast_mode = svrc_pkg::CODE_REGULATE;
            peak_sum = reading;
          end
          if ({1'b0, interval_cnt} + 9'd1 >= {1'b0, check_interval})
            interval_cnt = '0;
          else
            interval_cnt = interval_cnt + 8'd1;
        end
        default: begin
          relay_state = (reading > regulate_thr);
        end
      endcase
    end
    expected_status.push_back('{relay_state, coast_mode, fresh, last_sum});
  endtask

  task automatic send_sample(input logic [svrc_pkg::SAMPLE_W-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= sample;
    do @(posedge clk); while (in_stall);
    advance_controller(sample);
  endtask

  task automatic wait_for_results;
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [svrc_pkg::CFG_DATA_W-1:0] heat,
                                input logic [svrc_pkg::CFG_DATA_W-1:0] regul,
                                input logic [svrc_pkg::CFG_DATA_W-1:0] adjust,
                                input logic [svrc_pkg::CFG_DATA_W-1:0] interval);
    logic [svrc_pkg::CFG_IDX_W-1:0]  idx[4];
    logic [svrc_pkg::CFG_DATA_W-1:0] val[4];
    idx = '{svrc_pkg::CFG_HEAT_EXIT, svrc_pkg::CFG_REGULATE, svrc_pkg::CFG_ADJUST,
            svrc_pkg::CFG_INTERVAL};
    val = '{heat, regul, adjust, interval};
    wait_for_results();
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        svrc_pkg::CFG_HEAT_EXIT: heat_exit_thr  = val[k];
        svrc_pkg::CFG_REGULATE:  regulate_thr   = val[k];
        svrc_pkg::CFG_ADJUST:    relay_adjust   = val[k][svrc_pkg::ADJ_W-1:0];
        default:                 check_interval = val[k][svrc_pkg::INTERVAL_W-1:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [svrc_pkg::SAMPLE_W-1:0] near_level(input int level);
    int v;
    v = level + $urandom_range(120) - 60;
    if (v < 0)
      v = 0;
    if (v > 1023)
      v = 1023;
    return svrc_pkg::SAMPLE_W'(v);
  endfunction

  // Full-scale reading with the relay on, then an all-zero reading whose
  // correction would go below zero, with a heating threshold that never exits.
  task automatic test_heat_directed;
    repeat (N_SAMPLES) send_sample('1);
    apply_settings('0, svrc_pkg::REGULATE_RESET, 14'd1023, 14'(svrc_pkg::INTERVAL_RESET));
    repeat (N_SAMPLES) send_sample('0);
  endtask

  task automatic test_heat_random;
    apply_settings('0, 14'($urandom_range(10230)), 14'($urandom_range(1023)), 14'd60);
    repeat (6 * N_SAMPLES) send_sample(svrc_pkg::SAMPLE_W'($urandom));
  endtask

  // Readings fall steadily so the coasting phase lasts, while the check
  // interval is varied; full-scale readings then end it.
  task automatic test_peak_search;
    int hi;
    send_idle_pct = 72;
    apply_settings('1, svrc_pkg::REGULATE_RESET, 14'($urandom_range(1023)), '0);
    repeat (N_SAMPLES) send_sample(svrc_pkg::SAMPLE_W'($urandom));
    for (int r = 0; r < 12; r++) begin
      if (r == 6)
        apply_settings('1, svrc_pkg::REGULATE_RESET, 14'($urandom_range(1023)), 14'd3);
      if (r == 10)
        apply_settings('1, svrc_pkg::REGULATE_RESET, 14'($urandom_range(1023)), 14'h3F02);
      hi = 1023 - 80 * r;
      repeat (N_SAMPLES) send_sample(svrc_pkg::SAMPLE_W'($urandom_range(hi, hi - 40)));
    end
    while (coast_mode == svrc_pkg::CODE_COAST) begin
      repeat (N_SAMPLES) send_sample('1);
    end
    send_idle_pct = 0;
  endtask

  task automatic test_regulation;
    logic [svrc_pkg::CFG_DATA_W-1:0] regul;
    logic [svrc_pkg::CFG_DATA_W-1:0] adjust;
    int                              level;
    for (int ph = 0; ph < 4; ph++) begin
      regul  = (ph == 0) ? '1 : (ph == 1) ? '0 : 14'($urandom_range(300, 9800));
      adjust = (ph == 0) ? '0 : (ph == 1) ? '1 : 14'($urandom_range(1023));
      apply_settings(14'($urandom), regul, adjust,
                     (ph == 2) ? 14'd255 : 14'($urandom_range(255)));
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      level = (regul / 10 > 1023) ? 1023 : regul / 10;
      repeat (50) begin
        send_sample(($urandom_range(99) < 80) ? near_level(level) :
                    svrc_pkg::SAMPLE_W'($urandom_range(1023)));
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // The receiver holds off long enough for the block to fill and stall
  // its input while samples keep being offered.
  task automatic test_backpressure;
    apply_settings(14'($urandom), 14'($urandom_range(4000, 6000)),
                   14'($urandom_range(1023)), 14'($urandom_range(255)));
    fork
      begin
        hold_on <= 1'b1;
        repeat (80) @(posedge clk);
        hold_on <= 1'b0;
      end
      repeat (40) send_sample(near_level(int'(regulate_thr / 10)));
    join
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_heat_directed();
    test_heat_random();
    test_peak_search();
    test_regulation();
    test_backpressure();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
